FILE: sv/cct_pkg.sv
// Shared types and constants for the colour temperature unit.
`timescale 1ns / 1ps

package cct_pkg;

  // Field widths fixed by the sample format.
  localparam int unsigned CHAN_W     = 16;
  localparam int unsigned SETTING_W  = 8;
  localparam int unsigned DIVIDEND_W = 28;

  // Estimator constants.
  localparam logic [11:0] CCT_SLOPE  = 12'd3810;
  localparam logic [15:0] CCT_OFFSET = 16'd1391;

  // Saturation level constants.
  localparam logic [15:0] DIGITAL_SAT        = 16'd65535;
  localparam logic [8:0]  CYCLE_BASE         = 9'd256;
  localparam logic [8:0]  ANALOG_CYCLE_LIMIT = 9'd63;
  localparam int unsigned COUNTS_PER_CYCLE   = 1024;
  localparam logic [9:0]  SAT_PER_CYCLE      = 10'(COUNTS_PER_CYCLE - COUNTS_PER_CYCLE / 4);

  // Divider shape: two quotient bits per pipeline stage.
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = DIVIDEND_W / BITS_PER_STAGE;

  // One classified request waiting for the divider.
  typedef struct packed {
    logic                  zero;
    logic [CHAN_W-1:0]     divisor;
    logic [DIVIDEND_W-1:0] dividend;
  } cct_job_t;

  // Occupancy of the front pipeline, used for the busy credit.
  typedef struct packed {
    logic f1_valid;
    logic f2_valid;
  } cct_front_stat_t;

endpackage

FILE: sv/ir_compensated_color_temperature_unit.sv
// Throughput: one request per cycle; two front stages, a short queue and a
// fourteen-stage divider retiring two quotient bits per stage.
// busy rises only if the queue credit runs out, which cannot happen at DEPTH >= 4,
// since the receiver cannot stall and the divider drains one request a cycle.
// Reset (rst_n low, synchronous) empties the pipeline and clears the register to 0.
`timescale 1ns / 1ps

module ir_compensated_color_temperature_unit import cct_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [CHAN_W-1:0]    in_red_count,
  input  logic [CHAN_W-1:0]    in_green_count,
  input  logic [CHAN_W-1:0]    in_blue_count,
  input  logic [CHAN_W-1:0]    in_clear_count,
  output logic                 out_strobe,
  output logic [CHAN_W-1:0]    out_kelvin,
  input  logic                 cfg_we,
  input  logic [SETTING_W-1:0] cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic            accept;
  logic            push;
  cct_job_t        push_job;
  cct_front_stat_t stat;
  logic            head_valid;
  cct_job_t        head_job;
  logic [CNT_W-1:0] count;
  logic [CNT_W:0]   pending;

  // A request is taken when start is high and there is room for it downstream.
  assign accept  = start && !busy;
  assign pending = {1'b0, count} + {{CNT_W{1'b0}}, stat.f1_valid}
                 + {{CNT_W{1'b0}}, stat.f2_valid};
  assign busy    = (pending >= (CNT_W + 1)'(DEPTH));

  cct_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .red      (in_red_count),
    .green    (in_green_count),
    .blue     (in_blue_count),
    .clear    (in_clear_count),
    .push     (push),
    .push_job (push_job),
    .stat     (stat)
  );

  cct_queue #(
    .DEPTH(DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (head_valid),
    .head_valid(head_valid),
    .head_job  (head_job),
    .count     (count)
  );

  // The divider takes the queue head every cycle it is present.
  cct_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (head_valid),
    .in_job    (head_job),
    .out_strobe(out_strobe),
    .out_kelvin(out_kelvin)
  );

endmodule

FILE: sv/cct_front.sv
// Front end: configuration register, saturation check, IR removal and scaling.
`timescale 1ns / 1ps

module cct_front import cct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [SETTING_W-1:0] cfg_wdata,
  input  logic                 accept,
  input  logic [CHAN_W-1:0]    red,
  input  logic [CHAN_W-1:0]    green,
  input  logic [CHAN_W-1:0]    blue,
  input  logic [CHAN_W-1:0]    clear,
  output logic                 push,
  output cct_job_t             push_job,
  output cct_front_stat_t      stat
);

  logic [SETTING_W-1:0] setting_r;

  logic              f1_valid_r;
  logic              f1_zero_r;
  logic [CHAN_W-1:0] f1_ir_r;
  logic [CHAN_W-1:0] f1_red_r;
  logic [CHAN_W-1:0] f1_blue_r;

  logic              f2_valid_r;
  logic              f2_zero_r;
  logic [CHAN_W-1:0] f2_red_r;
  logic [CHAN_W-1:0] f2_blue_r;

  logic [8:0]        cycles;
  logic [CHAN_W-1:0] sat_level;
  logic [17:0]       sum;
  logic [17:0]       diff;
  logic [CHAN_W-1:0] ir_nxt;
  logic              zero_nxt;
  logic [CHAN_W-1:0] red2_nxt;
  logic [CHAN_W-1:0] blue2_nxt;

  // Configuration register, written whenever the enable is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setting_r <= '0;
    end else if (cfg_we) begin
      setting_r <= cfg_wdata;
    end
  end

  // Saturation level: digital limit for long integrations, else 75 percent of full scale.
  always_comb begin
    cycles = CYCLE_BASE - {1'b0, setting_r};
    if (cycles > ANALOG_CYCLE_LIMIT) begin
      sat_level = DIGITAL_SAT;
    end else begin
      sat_level = 16'({10'b0, cycles[5:0]} * {6'b0, SAT_PER_CYCLE});
    end
  end

  // Stage one: classify the sample and estimate the IR content.
  always_comb begin
    sum      = {2'b0, red} + {2'b0, green} + {2'b0, blue};
    diff     = sum - {2'b0, clear};
    ir_nxt   = (sum > {2'b0, clear}) ? diff[16:1] : '0;
    zero_nxt = (clear == '0) || (clear >= sat_level);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else begin
      f1_valid_r <= accept;
    end
    f1_zero_r <= zero_nxt;
    f1_ir_r   <= ir_nxt;
    f1_red_r  <= red;
    f1_blue_r <= blue;
  end

  // Stage two: remove the IR estimate from red and blue, wrapping at 16 bits.
  assign red2_nxt  = f1_red_r - f1_ir_r;
  assign blue2_nxt = f1_blue_r - f1_ir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_valid_r <= 1'b0;
    end else begin
      f2_valid_r <= f1_valid_r;
    end
    f2_zero_r <= f1_zero_r || (red2_nxt == '0);
    f2_red_r  <= red2_nxt;
    f2_blue_r <= blue2_nxt;
  end

  // Scale blue by the slope and hand the request to the queue.
  assign push              = f2_valid_r;
  assign push_job.zero     = f2_zero_r;
  assign push_job.divisor  = f2_red_r;
  assign push_job.dividend = DIVIDEND_W'(CCT_SLOPE) * DIVIDEND_W'(f2_blue_r);

  assign stat.f1_valid = f1_valid_r;
  assign stat.f2_valid = f2_valid_r;

endmodule

FILE: sv/cct_queue.sv
// Short request queue between the front end and the divider.
`timescale 1ns / 1ps

module cct_queue import cct_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  cct_job_t                     push_job,
  input  logic                         pop,
  output logic                         head_valid,
  output cct_job_t                     head_job,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cct_job_t          slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign count      = count_r;

  // Storage slots carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // The busy credit must keep the queue from overflowing.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !do_pop && (count_r == CNT_W'(DEPTH))))
    else $error("queue written while full");

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: sv/cct_div_pipe.sv
// Back end: pipelined restoring divider and result register.
`timescale 1ns / 1ps

module cct_div_pipe import cct_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  cct_job_t          in_job,
  output logic              out_strobe,
  output logic [CHAN_W-1:0] out_kelvin
);

  logic                  v_r   [DIV_STAGES];
  logic                  z_r   [DIV_STAGES];
  logic [CHAN_W-1:0]     rem_r [DIV_STAGES];
  logic [CHAN_W-1:0]     quo_r [DIV_STAGES];
  logic [CHAN_W-1:0]     den_r [DIV_STAGES];
  logic [DIVIDEND_W-1:0] num_r [DIV_STAGES];

  logic              out_strobe_r;
  logic [CHAN_W-1:0] out_kelvin_r;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic                  v_in;
    logic                  z_in;
    logic [CHAN_W-1:0]     rem_in;
    logic [CHAN_W-1:0]     quo_in;
    logic [CHAN_W-1:0]     den_in;
    logic [DIVIDEND_W-1:0] num_in;
    logic [CHAN_W-1:0]     rem_nxt;
    logic [CHAN_W-1:0]     quo_nxt;
    logic [DIVIDEND_W-1:0] num_nxt;

    // The first stage starts from the queue head with a clear remainder.
    if (s == 0) begin : g_first
      assign v_in   = in_valid;
      assign z_in   = in_job.zero;
      assign rem_in = '0;
      assign quo_in = '0;
      assign den_in = in_job.divisor;
      assign num_in = in_job.dividend;
    end else begin : g_next
      assign v_in   = v_r[s-1];
      assign z_in   = z_r[s-1];
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign den_in = den_r[s-1];
      assign num_in = num_r[s-1];
    end

    // Two restoring steps; only the low 16 quotient bits are kept, as the sum wraps.
    always_comb begin
      logic [CHAN_W:0]       trial;
      logic [CHAN_W-1:0]     rem_w;
      logic [CHAN_W-1:0]     quo_w;
      logic [DIVIDEND_W-1:0] num_w;
      rem_w = rem_in;
      quo_w = quo_in;
      num_w = num_in;
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
        trial = {rem_w, num_w[DIVIDEND_W-1]};
        num_w = {num_w[DIVIDEND_W-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_w = CHAN_W'(trial - {1'b0, den_in});
          quo_w = {quo_w[CHAN_W-2:0], 1'b1};
        end else begin
          rem_w = trial[CHAN_W-1:0];
          quo_w = {quo_w[CHAN_W-2:0], 1'b0};
        end
      end
      rem_nxt = rem_w;
      quo_nxt = quo_w;
      num_nxt = num_w;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_in;
      end
      z_r[s]   <= z_in;
      rem_r[s] <= rem_nxt;
      quo_r[s] <= quo_nxt;
      den_r[s] <= den_in;
      num_r[s] <= num_nxt;
    end
  end

  // Result register: add the offset, or give zero for a rejected sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= v_r[DIV_STAGES-1];
    end
    out_kelvin_r <= z_r[DIV_STAGES-1] ? '0 : quo_r[DIV_STAGES-1] + CCT_OFFSET;
  end

  assign out_strobe = out_strobe_r;
  assign out_kelvin = out_kelvin_r;

  // A request leaves the last stage a fixed number of cycles after entering.
  assert property (@(posedge clk) disable iff (!rst_n)
    v_r[DIV_STAGES-1] |-> $past(v_r[0], DIV_STAGES - 1))
    else $error("divider stage valid out of step");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the IR-compensated colour temperature unit.
`timescale 1ns / 1ps

module tb;
  import cct_pkg::*;

  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned PHASE_REQUESTS  = 240;
  localparam int unsigned RUN_LIMIT_NS    = 4_000_000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [CHAN_W-1:0]    in_red_count;
  logic [CHAN_W-1:0]    in_green_count;
  logic [CHAN_W-1:0]    in_blue_count;
  logic [CHAN_W-1:0]    in_clear_count;
  logic                 out_strobe;
  logic [CHAN_W-1:0]    out_kelvin;
  logic                 cfg_we;
  logic [SETTING_W-1:0] cfg_wdata;

  // Expected kelvin values for accepted requests, with a private copy of the
  // integration setting used to predict them.
  class kelvin_scoreboard;
    logic [SETTING_W-1:0] integration_setting;
    logic [CHAN_W-1:0]    expected_kelvin[$];
    int unsigned          mismatches;

    function new();
      integration_setting = '0;
      mismatches          = 0;
    endfunction

    function void set_integration(logic [SETTING_W-1:0] value);
      integration_setting = value;
    endfunction

    // Clear counts at or above this level are treated as saturated.
    function int unsigned saturation_limit();
      logic [8:0]  cycles;
      int unsigned raw_level;
      cycles = CYCLE_BASE - {1'b0, integration_setting};
      if (cycles > ANALOG_CYCLE_LIMIT) begin
        return int'(DIGITAL_SAT);
      end
      raw_level = COUNTS_PER_CYCLE * int'(cycles);
      return raw_level - raw_level / 4;
    endfunction

    function logic [CHAN_W-1:0] predict_kelvin(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                                               logic [CHAN_W-1:0] blue, logic [CHAN_W-1:0] clear);
      logic [17:0]           channel_sum;
      logic [CHAN_W-1:0]     ir_part;
      logic [CHAN_W-1:0]     red_net;
      logic [CHAN_W-1:0]     blue_net;
      logic [DIVIDEND_W-1:0] scaled_blue;
      logic [DIVIDEND_W-1:0] quotient;
      if (clear == '0) begin
        return '0;
      end
      if (int'(clear) >= saturation_limit()) begin
        return '0;
      end
      // Half of the excess of the three colour channels over clear is taken as IR.
      channel_sum = 18'(red) + 18'(green) + 18'(blue);
      if (channel_sum > 18'(clear)) begin
        ir_part = CHAN_W'((channel_sum - 18'(clear)) >> 1);
      end else begin
        ir_part = '0;
      end
      red_net  = red - ir_part;
      blue_net = blue - ir_part;
      if (red_net == '0) begin
        return '0;
      end
      scaled_blue = DIVIDEND_W'(CCT_SLOPE) * DIVIDEND_W'(blue_net);
      quotient    = scaled_blue / DIVIDEND_W'(red_net);
      return CHAN_W'(quotient) + CCT_OFFSET;
    endfunction

    function void note_request(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                               logic [CHAN_W-1:0] blue, logic [CHAN_W-1:0] clear);
      expected_kelvin.push_back(predict_kelvin(red, green, blue, clear));
    endfunction

    task report_mismatch(string what);
      $display("tb: mismatch at %0t ns: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(logic [CHAN_W-1:0] kelvin);
      logic [CHAN_W-1:0] wanted;
      if (expected_kelvin.size() == 0) begin
        report_mismatch($sformatf("kelvin %0d with no request outstanding", kelvin));
        return;
      end
      wanted = expected_kelvin.pop_front();
      if (kelvin !== wanted) begin
        report_mismatch($sformatf("kelvin %0d, expected %0d", kelvin, wanted));
      end
    endtask

    function int unsigned outstanding();
      return expected_kelvin.size();
    endfunction
  endclass

  kelvin_scoreboard sb = new();

  ir_compensated_color_temperature_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_red_count   (in_red_count),
    .in_green_count (in_green_count),
    .in_blue_count  (in_blue_count),
    .in_clear_count (in_clear_count),
    .out_strobe     (out_strobe),
    .out_kelvin     (out_kelvin),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Results are checked before a request accepted at the same edge is noted,
  // so a stray result is never matched against a brand-new expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        sb.check_result(out_kelvin);
      end
      if (start && !busy) begin
        sb.note_request(in_red_count, in_green_count, in_blue_count, in_clear_count);
      end
    end
  end

  // Presents one request and holds it until the unit takes it.
  task automatic send_request(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                              input logic [CHAN_W-1:0] blue, input logic [CHAN_W-1:0] clear);
    @(negedge clk);
    start          <= 1'b1;
    in_red_count   <= red;
    in_green_count <= green;
    in_blue_count  <= blue;
    in_clear_count <= clear;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int unsigned count);
    repeat (count) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Stops sending and waits until every outstanding request has produced its result.
  task automatic drain_requests();
    idle_cycles(1);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_integration(input logic [SETTING_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_integration(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A value near the interesting boundaries of a channel.
  function automatic logic [CHAN_W-1:0] boundary_count(input int unsigned limit);
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'hFFFE;
      4: return CHAN_W'(limit - 1);
      5: return CHAN_W'(limit);
      default: return CHAN_W'($urandom());
    endcase
  endfunction

  function automatic int unsigned clip_count(input int unsigned value);
    return (value > 65535) ? 65535 : value;
  endfunction

  // Mostly plausible samples below saturation, with some noise and boundary values.
  task automatic make_sample(output logic [CHAN_W-1:0] red, output logic [CHAN_W-1:0] green,
                             output logic [CHAN_W-1:0] blue, output logic [CHAN_W-1:0] clear);
    int unsigned limit;
    int unsigned clear_val;
    int unsigned mode;
    limit = sb.saturation_limit();
    mode  = $urandom_range(0, 9);
    if (mode == 0) begin
      red   = CHAN_W'($urandom());
      green = CHAN_W'($urandom());
      blue  = CHAN_W'($urandom());
      clear = CHAN_W'($urandom());
    end else if (mode == 1) begin
      red   = boundary_count(limit);
      green = boundary_count(limit);
      blue  = boundary_count(limit);
      clear = boundary_count(limit);
    end else begin
      clear_val = $urandom_range(1, limit - 1);
      clear = CHAN_W'(clear_val);
      red   = CHAN_W'(clip_count(clear_val * $urandom_range(0, 120) / 100));
      green = CHAN_W'(clip_count(clear_val * $urandom_range(0, 120) / 100));
      blue  = CHAN_W'(clip_count(clear_val * $urandom_range(0, 120) / 100));
    end
  endtask

  // One phase of random requests at a given setting, with optional bursts of idling and an optional drain midway.
  task automatic random_phase(input logic [SETTING_W-1:0] setting, input bit with_gaps,
                              input bit drain_midway);
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] clear;
    write_integration(setting);
    for (int unsigned n = 0; n < PHASE_REQUESTS; n++) begin
      if (with_gaps && ((n / 40) % 2 == 0) && $urandom_range(0, 4) == 0) begin
        idle_cycles($urandom_range(1, 15));
      end
      if (drain_midway && n == PHASE_REQUESTS / 2) begin
        drain_requests();
      end
      make_sample(red, green, blue, clear);
      send_request(red, green, blue, clear);
    end
    drain_requests();
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_red_count   = '0;
    in_green_count = '0;
    in_blue_count  = '0;
    in_clear_count = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting: digital saturation and the arithmetic corner cases.
    send_request(16'd0, 16'd0, 16'd0, 16'd0);
    send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(16'd100, 16'd200, 16'd300, 16'hFFFE);
    send_request(16'd0, 16'd0, 16'd0, 16'd1);
    send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
    send_request(16'd1, 16'd0, 16'd10, 16'd1);
    send_request(16'd1, 16'd0, 16'd100, 16'd200);
    send_request(16'd100, 16'd100, 16'd100, 16'd300);
    send_request(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFE);
    send_request(16'd0, 16'hFFFF, 16'd0, 16'd1);
    drain_requests();

    // Shortest integration: saturation at 768 counts.
    write_integration(8'd255);
    send_request(16'd100, 16'd100, 16'd100, 16'd767);
    send_request(16'd100, 16'd100, 16'd100, 16'd768);
    send_request(16'd1, 16'd1, 16'd1, 16'd1);
    drain_requests();

    // Either side of the boundary between analogue and digital saturation.
    write_integration(8'd193);
    send_request(16'd1000, 16'd2000, 16'd3000, 16'd48383);
    send_request(16'd1000, 16'd2000, 16'd3000, 16'd48384);
    drain_requests();
    write_integration(8'd192);
    send_request(16'd1000, 16'd2000, 16'd3000, 16'hFFFE);
    send_request(16'd1000, 16'd2000, 16'd3000, 16'hFFFF);
    drain_requests();

    // Random requests over a range of settings; the last phase runs without gaps.
    random_phase(8'd0, 1'b1, 1'b0);
    random_phase(8'd255, 1'b1, 1'b0);
    random_phase(8'd193, 1'b1, 1'b1);
    random_phase(8'd192, 1'b1, 1'b0);
    random_phase(SETTING_W'($urandom_range(193, 254)), 1'b1, 1'b0);
    random_phase(SETTING_W'($urandom()), 1'b1, 1'b0);
    random_phase(SETTING_W'($urandom_range(220, 254)), 1'b1, 1'b0);
    random_phase(8'd0, 1'b0, 1'b0);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hang anywhere in the run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
